// ===== hw/rtl/utc_pkg.sv =====
// Shared types, constants and calendar helpers for the UTC to local date converter.
`default_nettype none

package utc_pkg;

   localparam int YEAR_W   = 12;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int HOUR_W   = 5;
   localparam int OFFSET_W = 6;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 6;

   localparam logic [CSR_INDEX_W-1:0] CSR_START_MONTH = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_DAY   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_END_MONTH   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_END_DAY     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_STD_OFFSET  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_DST_OFFSET  = 3'd5;

   localparam logic [MONTH_W-1:0]  RST_START_MONTH = 4'd3;
   localparam logic [DAY_W-1:0]    RST_START_DAY   = 5'd1;
   localparam logic [MONTH_W-1:0]  RST_END_MONTH   = 4'd11;
   localparam logic [DAY_W-1:0]    RST_END_DAY     = 5'd1;
   localparam logic [OFFSET_W-1:0] RST_STD_OFFSET  = 6'd0;
   localparam logic [OFFSET_W-1:0] RST_DST_OFFSET  = 6'd0;

   localparam int MONTHS_PER_YEAR = 12;
   localparam int HOURS_PER_DAY   = 24;
   localparam int CENTURY         = 100;
   localparam int MAX_CENTURY     = ((1 << YEAR_W) - 1) / CENTURY;

   localparam logic [DAY_W-1:0] LONG_MONTH_DAYS = 5'd31;
   localparam logic [DAY_W-1:0] LEAP_FEB_DAYS   = 5'd29;
   localparam logic [MONTH_W-1:0] FEBRUARY      = 4'd2;

   localparam logic [DAY_W-1:0] MONTH_DAYS [MONTHS_PER_YEAR] = '{
      5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
      5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
   };

   typedef struct packed {
      logic [YEAR_W-1:0]  utc_year;
      logic [MONTH_W-1:0] utc_month;
      logic [DAY_W-1:0]   utc_day;
      logic [HOUR_W-1:0]  utc_hour;
   } req_type;

   typedef struct packed {
      logic [YEAR_W-1:0]  local_year;
      logic [MONTH_W-1:0] local_month;
      logic [DAY_W-1:0]   local_day;
      logic [HOUR_W-1:0]  local_hour;
      logic               dst_active;
   } rsp_type;

   typedef struct packed {
      logic [MONTH_W-1:0]  start_month;
      logic [DAY_W-1:0]    start_day;
      logic [MONTH_W-1:0]  end_month;
      logic [DAY_W-1:0]    end_day;
      logic [OFFSET_W-1:0] std_offset;
      logic [OFFSET_W-1:0] dst_offset;
   } cfg_type;

   // Year divisible by 100: compare against every multiple in range.
   function automatic logic is_century(input logic [YEAR_W-1:0] year);
      logic hit;
      hit = 1'b0;
      for (int k = 0; k <= MAX_CENTURY; k++) begin
         hit = hit | (year == YEAR_W'(k * CENTURY));
      end
      return hit;
   endfunction

   // A century year is divisible by 400 exactly when it is divisible by 16.
   function automatic logic is_leap(input logic [YEAR_W-1:0] year);
      return (year[1:0] == 2'b00) && (!is_century(year) || (year[3:0] == 4'b0000));
   endfunction

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                  input logic leap);
      logic [DAY_W-1:0] len;
      if (month == 4'd0 || month > 4'(MONTHS_PER_YEAR)) begin
         len = LONG_MONTH_DAYS;
      end else if (month == FEBRUARY && leap) begin
         len = LEAP_FEB_DAYS;
      end else begin
         len = MONTH_DAYS[month - 4'd1];
      end
      return len;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/utc_to_local_date_with_dst.sv =====
// Top level: UTC date and hour to local date and hour with a DST window.
//
// One response per request. A request is registered on acceptance, converted by
// the datapath and registered again; one request per cycle is taken sustained
// while the response side is not stalled. The input and output registers form a
// two-entry pipeline, so one more request is taken while a finished response
// waits on rsp_stall. The configuration port is always ready; the user is to write
// it only while no request is in flight; the block does not enforce this.
`default_nettype none

module utc_to_local_date_with_dst (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_stall,
   input  utc_pkg::req_type                  req_payload,
   output logic                              rsp_valid,
   input  wire                               rsp_stall,
   output utc_pkg::rsp_type                  rsp_payload,
   input  wire                               csr_valid,
   output logic                              csr_ready,
   input  wire  [utc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire  [utc_pkg::CSR_DATA_W-1:0]    csr_data
);
   import utc_pkg::*;

   cfg_type cfg;
   req_type s1_req_ff;
   rsp_type s2_rsp_ff, s2_rsp_in;
   logic    s1_valid_ff, s1_valid_in;
   logic    s2_valid_ff, s2_valid_in;
   logic    adv1, adv2;

   utc_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   utc_conv u_conv (
      .req (s1_req_ff),
      .cfg (cfg),
      .rsp (s2_rsp_in)
   );

   assign adv2      = !s2_valid_ff || !rsp_stall;
   assign adv1      = !s1_valid_ff || adv2;
   assign req_stall = !adv1;

   assign s1_valid_in = adv1 ? req_valid : s1_valid_ff;
   assign s2_valid_in = adv2 ? s1_valid_ff : s2_valid_ff;

   assign rsp_valid   = s2_valid_ff;
   assign rsp_payload = s2_rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_req_ff <= req_payload;
      end
      if (adv2 && s1_valid_ff) begin
         s2_rsp_ff <= s2_rsp_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/utc_cfg.sv =====
// Configuration registers for the DST window and hour offsets.
`default_nettype none

module utc_cfg (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                csr_valid,
   output logic                               csr_ready,
   input  wire  [utc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire  [utc_pkg::CSR_DATA_W-1:0]     csr_data,
   output utc_pkg::cfg_type                   cfg
);
   import utc_pkg::*;

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_START_MONTH: cfg_in.start_month = csr_data[MONTH_W-1:0];
            CSR_START_DAY:   cfg_in.start_day   = csr_data[DAY_W-1:0];
            CSR_END_MONTH:   cfg_in.end_month   = csr_data[MONTH_W-1:0];
            CSR_END_DAY:     cfg_in.end_day     = csr_data[DAY_W-1:0];
            CSR_STD_OFFSET:  cfg_in.std_offset  = csr_data[OFFSET_W-1:0];
            CSR_DST_OFFSET:  cfg_in.dst_offset  = csr_data[OFFSET_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_month <= RST_START_MONTH;
         cfg_ff.start_day   <= RST_START_DAY;
         cfg_ff.end_month   <= RST_END_MONTH;
         cfg_ff.end_day     <= RST_END_DAY;
         cfg_ff.std_offset  <= RST_STD_OFFSET;
         cfg_ff.dst_offset  <= RST_DST_OFFSET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/utc_conv.sv =====
// Conversion datapath: DST decision, hour offset and day/month/year carry.
`default_nettype none

module utc_conv (
   input  utc_pkg::req_type  req,
   input  utc_pkg::cfg_type  cfg,
   output utc_pkg::rsp_type  rsp
);
   import utc_pkg::*;

   logic                      dst;
   logic                      leap;
   logic [OFFSET_W-1:0]       offset;
   logic signed [6:0]         h_sum;
   logic signed [6:0]         h_adj;
   logic                      day_inc;
   logic                      day_dec;
   logic [DAY_W-1:0]          len_cur;
   logic [DAY_W-1:0]          len_prev;
   logic signed [6:0]         d_sum;
   logic                      mon_inc;
   logic                      mon_dec;
   logic signed [5:0]         m_sum;

   always_comb begin
      if (cfg.start_month == cfg.end_month) begin
         dst = (req.utc_month == cfg.start_month) && (req.utc_day >= cfg.start_day) &&
               (req.utc_day < cfg.end_day);
      end else begin
         dst = ((req.utc_month == cfg.start_month) && (req.utc_day >= cfg.start_day)) ||
               ((req.utc_month > cfg.start_month) && (req.utc_month < cfg.end_month)) ||
               ((req.utc_month == cfg.end_month) && (req.utc_day < cfg.end_day));
      end

      offset = dst ? cfg.dst_offset : cfg.std_offset;
      h_sum  = signed'({2'b00, req.utc_hour}) + signed'({offset[OFFSET_W-1], offset});
      day_inc = 1'b0;
      day_dec = 1'b0;
      if (h_sum >= 7'sd24) begin
         h_adj   = h_sum - 7'sd24;
         day_inc = 1'b1;
      end else if (h_sum < 7'sd0) begin
         h_adj   = h_sum + 7'sd24;
         day_dec = 1'b1;
      end else begin
         h_adj = h_sum;
      end

      leap    = is_leap(req.utc_year);
      len_cur = month_len(req.utc_month, leap);
      if (req.utc_month inside {[4'd2:4'd12]}) begin
         len_prev = month_len(req.utc_month - 4'd1, leap);
      end else begin
         len_prev = LONG_MONTH_DAYS;
      end

      d_sum = signed'({2'b00, req.utc_day}) + (day_inc ? 7'sd1 : 7'sd0) -
              (day_dec ? 7'sd1 : 7'sd0);
      mon_inc = 1'b0;
      mon_dec = 1'b0;
      if (d_sum > signed'({2'b00, len_cur})) begin
         rsp.local_day = 5'd1;
         mon_inc       = 1'b1;
      end else if (d_sum < 7'sd1) begin
         rsp.local_day = len_prev;
         mon_dec       = 1'b1;
      end else begin
         rsp.local_day = d_sum[DAY_W-1:0];
      end

      m_sum = signed'({2'b00, req.utc_month}) + (mon_inc ? 6'sd1 : 6'sd0) -
              (mon_dec ? 6'sd1 : 6'sd0);
      if (m_sum > 6'sd12) begin
         rsp.local_month = 4'd1;
         rsp.local_year  = req.utc_year + 12'd1;
      end else if (m_sum < 6'sd1) begin
         rsp.local_month = 4'(MONTHS_PER_YEAR);
         rsp.local_year  = req.utc_year - 12'd1;
      end else begin
         rsp.local_month = m_sum[MONTH_W-1:0];
         rsp.local_year  = req.utc_year;
      end

      rsp.local_hour = h_adj[HOUR_W-1:0];
      rsp.dst_active = dst;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/utc_checker.sv =====
// Port-level assertions for the converter and their bind to the top level.
`default_nettype none

module utc_checker (
   input wire               clock,
   input wire               reset,
   input wire               req_valid,
   input wire               req_stall,
   input wire               rsp_valid,
   input wire               rsp_stall,
   input utc_pkg::rsp_type  rsp_payload
);
   import utc_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled while the output side is free");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 !rsp_stall |=> rsp_valid)
      else $error("accepted request did not reach the output");

endmodule

bind utc_to_local_date_with_dst utc_checker u_utc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

`default_nettype wire
